// File: rtl/core/assert_macros.svh
// Assertion macros shared by the keypad scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while the asynchronous reset is asserted.
`define KPSR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("keypad scanner: assertion failed");

// Clocked check that also holds during reset.
`define KPSR_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("keypad scanner: assertion failed");

`endif

// File: rtl/core/kpsr_pkg.sv
// Types and constants shared by the keypad scanner modules.
`default_nettype none

package kpsr_pkg;

	localparam int unsigned NUM_PINS  = 3;
	localparam int unsigned NUM_KEYS  = 6;
	localparam int unsigned NUM_SLOTS = 9;

	// Event slots in emission order: keys 0..5, then repeat, knob and scan done.
	localparam logic [3:0] SLOT_REPEAT = 4'd6;
	localparam logic [3:0] SLOT_KNOB   = 4'd7;
	localparam logic [3:0] SLOT_DONE   = 4'd8;

	// Configuration register indexes.
	localparam logic REG_REPEAT_DELAY = 1'b0;
	localparam logic REG_REPEAT_SPEED = 1'b1;

	typedef enum logic [2:0] {
		EV_KEY_DOWN   = 3'd0,
		EV_KEY_UP     = 3'd1,
		EV_KEY_REPEAT = 3'd2,
		EV_KNOB       = 3'd3,
		EV_SCAN_DONE  = 3'd4
	} event_kind_t;

	// Everything the back end needs to emit the events of one scan tick.
	typedef struct packed {
		logic [5:0]        chg;      // keys whose state changed
		logic [5:0]        cur;      // new key state
		logic              rpt;      // a repeat is due
		logic [2:0]        rkey;     // key that repeats
		logic              knob_nz;  // knob moved
		logic signed [7:0] delta;    // knob movement in detents
		logic [1:0]        row;      // pin to drive on the next tick
	} tick_rec_t;

endpackage

`default_nettype wire

// File: rtl/core/kpsr_front.sv
// Front end: scan state, repeat timing and knob tracking, one tick per cycle while the queue has room.
`default_nettype none

module kpsr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                push,
	input  wire logic [2:0]          pin_levels,
	input  wire logic [31:0]         time_now,
	input  wire logic [9:0]          quad_count,
	output kpsr_pkg::tick_rec_t      rec
);

	logic [7:0]  repeat_delay_q;
	logic [7:0]  repeat_speed_q;
	logic [5:0]  button_bits_q;
	logic [1:0]  drive_row_q;
	logic [2:0]  button_cursor_q;
	logic [2:0]  held_key_q;
	logic        held_valid_q;
	logic [31:0] repeat_due_q;
	logic [7:0]  prev_knob_q;

	logic [5:0]  cur;
	logic [2:0]  cursor;
	logic [1:0]  row_n;
	logic [2:0]  cursor_n;
	logic [5:0]  changed;
	logic [2:0]  hk;
	logic        hv;
	logic        press;
	logic [31:0] diff;
	logic        fire;
	logic [31:0] due_n;
	logic [7:0]  knob;

	always_comb begin
		cur    = button_bits_q;
		cursor = button_cursor_q;
		for (int p = 0; p < kpsr_pkg::NUM_PINS; p++) begin
			if (2'(p) != drive_row_q) begin
				if (cursor < 3'(kpsr_pkg::NUM_KEYS)) begin
					cur[cursor] = ~pin_levels[p];
				end
				cursor = cursor + 3'd1;
			end
		end
		if (drive_row_q >= 2'(kpsr_pkg::NUM_PINS - 1)) begin
			row_n    = 2'd0;
			cursor_n = 3'd0;
		end else begin
			row_n    = drive_row_q + 2'd1;
			cursor_n = cursor;
		end

		changed = cur ^ button_bits_q;
		hk      = held_key_q;
		hv      = held_valid_q;
		press   = 1'b0;
		for (int i = 0; i < kpsr_pkg::NUM_KEYS; i++) begin
			if (changed[i]) begin
				if (cur[i]) begin
					hk    = 3'(i);
					hv    = 1'b1;
					press = 1'b1;
				end else if (hv && hk == 3'(i)) begin
					hv = 1'b0;
				end
			end
		end

		// A press this tick moves the due time to now plus the delay, so the
		// signed difference is just four times the delay.
		diff = repeat_due_q - time_now;
		if (press) begin
			fire = hv && (repeat_delay_q == 8'd0);
		end else begin
			fire = hv && ((diff == 32'd0) || diff[31]);
		end

		if (fire) begin
			due_n = time_now + {22'd0, repeat_speed_q, 2'b00};
		end else if (press) begin
			due_n = time_now + {22'd0, repeat_delay_q, 2'b00};
		end else begin
			due_n = repeat_due_q;
		end

		knob = quad_count[9:2];

		rec.chg     = changed;
		rec.cur     = cur;
		rec.rpt     = fire;
		rec.rkey    = hk;
		rec.delta   = knob - prev_knob_q;
		rec.knob_nz = (knob != prev_knob_q);
		rec.row     = row_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q  <= 8'd0;
			repeat_speed_q  <= 8'd0;
			button_bits_q   <= 6'd0;
			drive_row_q     <= 2'd0;
			button_cursor_q <= 3'd0;
			held_key_q      <= 3'd0;
			held_valid_q    <= 1'b0;
			repeat_due_q    <= 32'd0;
			prev_knob_q     <= 8'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == kpsr_pkg::REG_REPEAT_DELAY) begin
					repeat_delay_q <= cfg_data;
				end
				if (cfg_index == kpsr_pkg::REG_REPEAT_SPEED) begin
					repeat_speed_q <= cfg_data;
				end
			end
			if (push) begin
				button_bits_q   <= cur;
				drive_row_q     <= row_n;
				button_cursor_q <= cursor_n;
				held_key_q      <= hk;
				held_valid_q    <= hv;
				repeat_due_q    <= due_n;
				prev_knob_q     <= knob;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/kpsr_fifo.sv
// Short queue of tick records between the front and back ends.
`default_nettype none
`include "assert_macros.svh"

module kpsr_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  kpsr_pkg::tick_rec_t      wr_rec,
	output logic                     full,
	input  wire logic                pop,
	output logic                     empty,
	output kpsr_pkg::tick_rec_t      rd_rec
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	kpsr_pkg::tick_rec_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`KPSR_ASSERT(a_no_push_when_full, full |-> !push)
	`KPSR_ASSERT(a_no_pop_when_empty, empty |-> !pop)

endmodule

`default_nettype wire

// File: rtl/core/kpsr_back.sv
// Back end: emits the events of each queued tick, one transfer per cycle while the master side accepts them.
`default_nettype none
`include "assert_macros.svh"

module kpsr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  kpsr_pkg::tick_rec_t      head,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kpsr_pkg::event_kind_t    out_kind,
	output logic signed [7:0]        out_value,
	output logic [1:0]               out_pin,
	output logic                     out_last
);

	logic [8:0]             sent_q;
	logic                   out_valid_q;
	kpsr_pkg::event_kind_t  out_kind_q;
	logic signed [7:0]      out_value_q;
	logic [1:0]             out_pin_q;
	logic                   out_last_q;

	logic [8:0]             pending;
	logic [3:0]             sel;
	logic                   load;
	kpsr_pkg::event_kind_t  kind;
	logic signed [7:0]      value;

	always_comb begin
		pending = {1'b1, head.knob_nz, head.rpt, head.chg} & ~sent_q;
		sel     = kpsr_pkg::SLOT_DONE;
		for (int s = kpsr_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
			if (pending[s]) begin
				sel = 4'(s);
			end
		end
		case (sel)
			kpsr_pkg::SLOT_REPEAT: begin
				kind  = kpsr_pkg::EV_KEY_REPEAT;
				value = {5'd0, head.rkey};
			end
			kpsr_pkg::SLOT_KNOB: begin
				kind  = kpsr_pkg::EV_KNOB;
				value = head.delta;
			end
			kpsr_pkg::SLOT_DONE: begin
				kind  = kpsr_pkg::EV_SCAN_DONE;
				value = 8'sd0;
			end
			default: begin
				kind  = head.cur[sel[2:0]] ? kpsr_pkg::EV_KEY_DOWN : kpsr_pkg::EV_KEY_UP;
				value = {5'd0, sel[2:0]};
			end
		endcase
		load = head_valid && (!out_valid_q || out_ready);
		pop  = load && (sel == kpsr_pkg::SLOT_DONE);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q  <= kind;
			out_value_q <= value;
			out_pin_q   <= head.row;
			out_last_q  <= (sel == kpsr_pkg::SLOT_DONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= 9'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				sent_q <= 9'd0;
			end else if (load) begin
				sent_q <= sent_q | (9'd1 << sel);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_value = out_value_q;
	assign out_pin   = out_pin_q;
	assign out_last  = out_last_q;

	`KPSR_ASSERT(a_last_marks_done, out_valid_q |-> (out_last_q == (out_kind_q == kpsr_pkg::EV_SCAN_DONE)))
	`KPSR_ASSERT(a_done_never_pending_sent, !sent_q[8])
	`KPSR_ASSERT(a_sent_clear_after_pop, pop |=> (sent_q == 9'd0))

endmodule

`default_nettype wire

// File: rtl/core/keypad_scan_repeat_knob_unit.sv
// Top level of the keypad matrix scanner with auto-repeat and rotary knob.
`default_nettype none

// Each transfer on the slave side is one scan tick: the levels of the three scan pins, the
// current time and the quadrature counter. The block answers with one to nine event
// transfers on the master side, in this order: key-down and key-up events for keys 0 to 5,
// at most one auto-repeat, at most one knob event and always a closing scan-done event,
// which is marked by tlast. Every event of a tick carries the pin to drive for the next tick.
// The front end takes a new tick in every cycle in which its queue has room and settles the
// scan state at once; the back end then emits one event transfer per cycle while the master
// side accepts them, one transfer per event of the tick, and the event serialiser in the back end
// sets the sustained rate. The queue between the two holds QUEUE_DEPTH ticks and an output
// register parts the back end from the master side. The repeat delay and speed registers
// are written through the plain write port and should only change while no tick is in flight.

module keypad_scan_repeat_knob_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Scan ticks in.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // pin_levels[2:0], time_now[34:3], quad_count[44:35]
	// Events out.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // event_kind[2:0], event_value[10:3], next_drive_pin[12:11]
	output logic             m_tlast    // last_event
);

	kpsr_pkg::tick_rec_t   wr_rec;
	kpsr_pkg::tick_rec_t   rd_rec;
	kpsr_pkg::event_kind_t out_kind;
	logic signed [7:0]     out_value;
	logic [1:0]            out_pin;
	logic                  full;
	logic                  empty;
	logic                  push;
	logic                  pop;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	kpsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.pin_levels (s_tdata[2:0]),
		.time_now   (s_tdata[34:3]),
		.quad_count (s_tdata[44:35]),
		.rec        (wr_rec)
	);

	kpsr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_rec (rd_rec)
	);

	kpsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!empty),
		.head       (rd_rec),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_value  (out_value),
		.out_pin    (out_pin),
		.out_last   (m_tlast)
	);

	assign m_tdata = {3'b000, out_pin, out_value, out_kind};

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the keypad scanner with auto-repeat and rotary knob.
`timescale 1ns / 100ps

module tb;

	// One event transfer as it should appear on the master side.
	typedef struct packed {
		kpsr_pkg::event_kind_t kind;
		logic [7:0]            value;
		logic [1:0]            pin;
		logic                  last;
	} scan_event_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = kpsr_pkg::REG_REPEAT_DELAY;
	logic [7:0]  cfg_data  = 8'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = 48'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	// Scanner state as the testbench believes it to be.
	logic [7:0]  delay_units;
	logic [7:0]  speed_units;
	logic [5:0]  key_state;
	logic [1:0]  scan_row;
	logic [2:0]  key_cursor;
	logic [2:0]  held_key;
	logic        held;
	logic [31:0] repeat_at;
	logic [7:0]  last_knob;

	scan_event_t pending_events[$];
	int          fault_count = 0;
	int          gap_pct     = 0;
	int          stall_pct   = 0;

	// Stimulus state for the random traffic.
	logic [5:0]  wanted_keys;
	logic [31:0] clock_now;
	logic [9:0]  quad_pos;

	keypad_scan_repeat_knob_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// A run that has not finished by now is hung.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic scan_event_t make_event(input kpsr_pkg::event_kind_t kind,
			input logic [7:0] value);
		scan_event_t ev;
		ev.kind  = kind;
		ev.value = value;
		ev.pin   = 2'd0;
		ev.last  = 1'b0;
		return ev;
	endfunction

	// Works out the events of one accepted scan tick and queues them. The sampling walks the
	// three pins in order, skipping the driven one, and writes each sample to the button at
	// the advancing cursor; cursor positions beyond the last button are dropped.
	task automatic predict_tick(input logic [2:0] pins, input logic [31:0] now,
			input logic [9:0] quad);
		logic [5:0]  keys;
		logic [5:0]  changed;
		logic [31:0] slack;
		logic [7:0]  knob;
		logic [7:0]  delta;
		scan_event_t tick_events[9];
		int          n;
		int          p;
		int          i;
		keys = key_state;
		n = 0;
		for (p = 0; p < kpsr_pkg::NUM_PINS; p++) begin
			if (p != scan_row) begin
				if (key_cursor < kpsr_pkg::NUM_KEYS)
					keys[key_cursor] = ~pins[p];
				key_cursor = key_cursor + 3'd1;
			end
		end
		scan_row = scan_row + 2'd1;
		if (scan_row >= kpsr_pkg::NUM_PINS) begin
			scan_row   = 2'd0;
			key_cursor = 3'd0;
		end
		// Key events in index order; a press arms the repeat, releasing the held key disarms it.
		changed = keys ^ key_state;
		for (i = 0; i < kpsr_pkg::NUM_KEYS; i++) begin
			if (changed[i]) begin
				if (keys[i]) begin
					held_key  = i[2:0];
					held      = 1'b1;
					repeat_at = now + {22'd0, delay_units, 2'b00};
					tick_events[n] = make_event(kpsr_pkg::EV_KEY_DOWN, i[7:0]);
				end else begin
					if (held && held_key == i[2:0])
						held = 1'b0;
					tick_events[n] = make_event(kpsr_pkg::EV_KEY_UP, i[7:0]);
				end
				n++;
			end
		end
		key_state = keys;
		// The due time is compared with wrap-around: due once the signed distance is not positive.
		if (held) begin
			slack = repeat_at - now;
			if ($signed(slack) <= 0) begin
				repeat_at = now + {22'd0, speed_units, 2'b00};
				tick_events[n] = make_event(kpsr_pkg::EV_KEY_REPEAT, {5'd0, held_key});
				n++;
			end
		end
		knob = quad[9:2];
		delta = knob - last_knob;
		last_knob = knob;
		if (delta != 8'd0) begin
			tick_events[n] = make_event(kpsr_pkg::EV_KNOB, delta);
			n++;
		end
		tick_events[n] = make_event(kpsr_pkg::EV_SCAN_DONE, 8'd0);
		n++;
		tick_events[n - 1].last = 1'b1;
		for (i = 0; i < n; i++) begin
			tick_events[i].pin = scan_row;
			pending_events.push_back(tick_events[i]);
		end
	endtask

	// Pin levels that report the wanted button state for the pin driven on the next tick. The
	// driven pin itself is ignored by the block, so it gets a random level.
	function automatic logic [2:0] pins_for_keys(input logic [5:0] keys);
		logic [2:0] levels;
		logic [2:0] c;
		int         p;
		levels = 3'($urandom);
		c = key_cursor;
		for (p = 0; p < kpsr_pkg::NUM_PINS; p++) begin
			if (p != scan_row) begin
				if (c < kpsr_pkg::NUM_KEYS)
					levels[p] = ~keys[c];
				c = c + 3'd1;
			end
		end
		return levels;
	endfunction

	task automatic note_fault(input string what, input logic [15:0] want, input logic [15:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	// Event checker. Every master-side transfer is compared with the oldest expected event,
	// and the ready line stalls at random according to the current phase.
	always @(posedge clk) begin
		scan_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				note_fault("event with none expected", 16'd0, {m_tlast, 2'd0, m_tdata[12:0]});
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[2:0] != want.kind)
					note_fault("event_kind", 16'(want.kind), 16'(m_tdata[2:0]));
				if (m_tdata[10:3] != want.value)
					note_fault("event_value", 16'(want.value), 16'(m_tdata[10:3]));
				if (m_tdata[12:11] != want.pin)
					note_fault("next_drive_pin", 16'(want.pin), 16'(m_tdata[12:11]));
				if (m_tlast != want.last)
					note_fault("last_event", 16'(want.last), 16'(m_tlast));
			end
		end
		m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// Offers one scan tick, after a random gap when the phase asks for one, and waits for the
	// transfer. tvalid is left high so that back-to-back ticks need no second assignment.
	task automatic send_tick(input logic [2:0] pins, input logic [31:0] now, input logic [9:0] quad);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'd0, quad, now, pins};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_tick(pins, now, quad);
	endtask

	// Holds the sender back until every expected event has arrived. Every tick ends in a
	// scan-done event, so an empty queue means the block is idle.
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The write enable stays high after the write; the caller drops it after its last write.
	task automatic write_reg(input logic index, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		if (index == kpsr_pkg::REG_REPEAT_DELAY)
			delay_units = value;
		else
			speed_units = value;
	endtask

	task automatic configure(input logic [7:0] delay, input logic [7:0] speed);
		drain_events();
		write_reg(kpsr_pkg::REG_REPEAT_DELAY, delay);
		write_reg(kpsr_pkg::REG_REPEAT_SPEED, speed);
		cfg_we <= 1'b0;
	endtask

	// Field extremes with the reset settings, where a held key repeats on every tick: all
	// buttons pressed and released, both time limits, the full knob range and a knob step of
	// -128 and +127, and the release of a key other than the held one.
	task automatic test_extremes();
		send_tick(3'b111, 32'h0000_0000, 10'd0);
		send_tick(3'b000, 32'hFFFF_FFFF, 10'd1023);
		send_tick(pins_for_keys(6'h3F), 32'h0000_0000, 10'd1023);
		send_tick(pins_for_keys(6'h3F), 32'h0000_0001, 10'd1023);
		send_tick(pins_for_keys(6'h3F), 32'h0000_0002, 10'd508);
		send_tick(pins_for_keys(6'h3F), 32'h0000_0003, 10'd1016);
		repeat (3) send_tick(pins_for_keys(6'b000011), 32'h8000_0000, 10'd1016);
		repeat (3) send_tick(pins_for_keys(6'b000000), 32'h7FFF_FFFF, 10'd0);
	endtask

	// Repeat timing across the wrap of the time counter: the longest first delay, then the
	// shortest non-zero interval, and a jump half the time range ahead.
	task automatic test_repeat_timing();
		configure(8'd255, 8'd1);
		send_tick(pins_for_keys(6'b000100), 32'hFFFF_FF00, 10'd0);
		send_tick(pins_for_keys(6'b000100), 32'hFFFF_FF04, 10'd0);
		send_tick(pins_for_keys(6'b000100), 32'hFFFF_FF08, 10'd0);
		send_tick(pins_for_keys(6'b000100), 32'h0000_0100, 10'd4);
		send_tick(pins_for_keys(6'b000100), 32'h0000_02F8, 10'd4);
		send_tick(pins_for_keys(6'b000100), 32'h0000_0304, 10'd4);
		send_tick(pins_for_keys(6'b000100), 32'h0000_0308, 10'd4);
		send_tick(pins_for_keys(6'b000100), 32'h8000_0300, 10'd4);
		repeat (3) send_tick(pins_for_keys(6'b000000), 32'h8000_0400, 10'd4);
	endtask

	// Mostly well-formed traffic: a button pattern that changes now and then and is held for
	// several scan rounds, time that runs forward in steps, and a knob that wanders. The rest
	// is noise on every field. Now and then the sender waits for the block to drain.
	task automatic test_random_traffic(input int items, input int gap, input int stall);
		int k;
		gap_pct   = gap;
		stall_pct = stall;
		for (k = 0; k < items; k++) begin
			if ($urandom_range(99) < 15) begin
				send_tick(3'($urandom), $urandom, 10'($urandom));
			end else begin
				if ($urandom_range(11) == 0) begin
					case ($urandom_range(3))
						0: wanted_keys = 6'd0;
						1: wanted_keys = 6'd1 << $urandom_range(5);
						2: wanted_keys = 6'($urandom);
						default: wanted_keys = wanted_keys ^ (6'd1 << $urandom_range(5));
					endcase
				end
				if ($urandom_range(29) == 0)
					clock_now = clock_now + $urandom_range(2000);
				else
					clock_now = clock_now + $urandom_range(64);
				if ($urandom_range(19) == 0)
					quad_pos = 10'($urandom);
				else
					quad_pos = quad_pos + 10'($urandom_range(24)) - 10'd12;
				send_tick(pins_for_keys(wanted_keys), clock_now, quad_pos);
			end
			if ($urandom_range(49) == 0)
				drain_events();
		end
		drain_events();
	endtask

	initial begin
		delay_units = 8'd0;
		speed_units = 8'd0;
		key_state   = 6'd0;
		scan_row    = 2'd0;
		key_cursor  = 3'd0;
		held_key    = 3'd0;
		held        = 1'b0;
		repeat_at   = 32'd0;
		last_knob   = 8'd0;
		wanted_keys = 6'd0;
		clock_now   = $urandom;
		quad_pos    = 10'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_extremes();
		test_repeat_timing();

		configure(8'd1, 8'd1);
		test_random_traffic(80, 0, 0);
		configure(8'd255, 8'd255);
		test_random_traffic(80, 45, 0);
		configure(8'd0, 8'd255);
		test_random_traffic(80, 0, 45);
		configure(8'd7, 8'd0);
		test_random_traffic(85, 17, 17);

		// Give the block time to show any stray event after the last expected one.
		gap_pct   = 0;
		stall_pct = 0;
		repeat (40) @(posedge clk);

		if (fault_count == 0 && pending_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
